[src/ugam_pkg.sv]
// Shared widths, constants, types and decode helpers for the glyph atlas mapper.
`timescale 1ns / 1ps

package ugam_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int CFG_W  = 11;
	localparam int SLOT_W = 14;
	localparam int COL_W  = 10;
	localparam int ORD_W  = 12;
	localparam int STEP_W = $clog2(SLOT_W);
	localparam int LEN_W  = 3;
	localparam int HCNT_W = 2;
	localparam int NRES_W = 2;

	localparam int MAX_STRING_GLYPHS = 4096;
	localparam int ORD_CAP_INT =
		((MAX_STRING_GLYPHS - 1) < 4095) ? (MAX_STRING_GLYPHS - 1) : 4095;
	localparam logic [ORD_W-1:0] ORDINAL_CAP = ORD_W'(ORD_CAP_INT);

	localparam logic [CP_W-1:0] CP_ASCII_LO  = CP_W'(32);
	localparam logic [CP_W-1:0] CP_ASCII_HI  = CP_W'(126);
	localparam logic [CP_W-1:0] CP_HANGUL_LO = CP_W'('hAC00);
	localparam logic [CP_W-1:0] CP_HANGUL_HI = CP_W'('hD7A3);
	localparam logic [CP_W-1:0] SLOT_HANGUL_BASE = CP_W'(95);

	localparam logic [CFG_W-1:0] ATLAS_MAX = CFG_W'(1024);
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
	localparam logic [BYTE_W-1:0] MARK_LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
	localparam logic [BYTE_W-1:0] MARK_LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
	localparam logic [BYTE_W-1:0] MARK_LEAD4 = 8'hF0;

	typedef struct packed {
		logic [SLOT_W-1:0] quot;
		logic [CFG_W-1:0]  rem;
	} div_res_t;

	// Sequence length set by a lead byte, 0 for a stray byte.
	function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] l;
		l = '0;
		if (!b[BYTE_W-1])
			l = LEN_W'(1);
		else if ((b & MASK_LEAD2) == MARK_LEAD2)
			l = LEN_W'(2);
		else if ((b & MASK_LEAD3) == MARK_LEAD3)
			l = LEN_W'(3);
		else if ((b & MASK_LEAD4) == MARK_LEAD4)
			l = LEN_W'(4);
		return l;
	endfunction

	function automatic logic [CP_W-1:0] assemble(input logic [BYTE_W-1:0] p0,
		input logic [BYTE_W-1:0] p1, input logic [BYTE_W-1:0] p2,
		input logic [BYTE_W-1:0] p3, input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] cp;
		case (len)
			LEN_W'(1): cp = {13'b0, p0};
			LEN_W'(2): cp = {10'b0, p0[4:0], p1[5:0]};
			LEN_W'(3): cp = {5'b0, p0[3:0], p1[5:0], p2[5:0]};
			default:   cp = {p0[2:0], p1[5:0], p2[5:0], p3[5:0]};
		endcase
		return cp;
	endfunction

endpackage

[src/ugam_divider.sv]
// Restoring divider: one quotient bit per cycle for the slot / columns split.
`timescale 1ns / 1ps

module ugam_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ugam_pkg::SLOT_W-1:0]   dividend,
	input  logic [ugam_pkg::CFG_W-1:0]    divisor,
	output logic                          done,
	output ugam_pkg::div_res_t            res
);

	logic                          busy_q;
	logic                          done_q;
	logic [ugam_pkg::STEP_W-1:0]   step_q;
	logic [ugam_pkg::SLOT_W-1:0]   den_q;
	logic [ugam_pkg::CFG_W-1:0]    dsr_q;
	logic [ugam_pkg::CFG_W-1:0]    rem_q;
	logic [ugam_pkg::CFG_W:0]      trial;
	logic                          ge;
	logic [ugam_pkg::CFG_W:0]      diff;

	assign trial = {rem_q, den_q[ugam_pkg::SLOT_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ugam_pkg::STEP_W'(ugam_pkg::SLOT_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the low end of the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			den_q <= {den_q[ugam_pkg::SLOT_W-2:0], ge};
			rem_q <= ge ? diff[ugam_pkg::CFG_W-1:0] : trial[ugam_pkg::CFG_W-1:0];
		end
	end

	assign done     = done_q;
	assign res.quot = den_q;
	assign res.rem  = rem_q;

endmodule

[src/utf8_glyph_atlas_mapper_unit.sv]
// Top level: lenient UTF-8 decode, atlas slot lookup and glyph result register.
`timescale 1ns / 1ps

// A byte that yields no glyph is taken without leaving idle. For each glyph
// the sequencer launches the shared divider, which runs its restoring steps
// (one quotient bit of the 14-bit atlas slot per cycle), then sees it done
// and loads the result register, which may wait on glyph_stall. A byte yields
// at most two glyphs, and text_stall stays high until the last is loaded. The
// result register frees the input side as soon as the last glyph of a byte is
// loaded. Configuration writes are always ready and belong in idle periods.

module utf8_glyph_atlas_mapper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ugam_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [ugam_pkg::BYTE_W-1:0]   text_byte,
	input  logic                          string_end,
	output logic                          glyph_valid,
	input  logic                          glyph_stall,
	output logic [ugam_pkg::CP_W-1:0]     code_point,
	output logic                          found,
	output logic [ugam_pkg::COL_W-1:0]    cell_column,
	output logic [ugam_pkg::COL_W-1:0]    cell_row,
	output logic [ugam_pkg::ORD_W-1:0]    glyph_ordinal,
	output logic                          run_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                          state_q;
	logic [ugam_pkg::CFG_W-1:0]          cols_q;
	logic [ugam_pkg::CFG_W-1:0]          rows_q;
	logic [ugam_pkg::BYTE_W-1:0]         held_q [3];
	logic [ugam_pkg::HCNT_W-1:0]         hcnt_q;
	logic [ugam_pkg::LEN_W-1:0]          need_q;
	logic [ugam_pkg::ORD_W-1:0]          ord_q;
	logic [ugam_pkg::CP_W-1:0]           cp0_q;
	logic [ugam_pkg::CP_W-1:0]           cp1_q;
	logic [ugam_pkg::NRES_W-1:0]         nres_q;
	logic                                idx_q;
	logic                                end_q;
	logic                                start_q;

	logic                                glyph_valid_q;
	logic [ugam_pkg::CP_W-1:0]           code_point_q;
	logic                                found_q;
	logic [ugam_pkg::COL_W-1:0]          cell_column_q;
	logic [ugam_pkg::COL_W-1:0]          cell_row_q;
	logic [ugam_pkg::ORD_W-1:0]          glyph_ordinal_q;
	logic                                run_last_q;

	logic [ugam_pkg::BYTE_W-1:0]         held_d [3];
	logic [ugam_pkg::HCNT_W-1:0]         hcnt_d;
	logic [ugam_pkg::LEN_W-1:0]          need_d;
	logic [ugam_pkg::NRES_W-1:0]         nres_d;
	logic [ugam_pkg::CP_W-1:0]           cpa_d;
	logic [ugam_pkg::CP_W-1:0]           cpb_d;

	logic                                text_take;
	logic                                out_free;
	logic                                last_res;
	logic [ugam_pkg::CP_W-1:0]           cur_cp;
	logic [ugam_pkg::CP_W-1:0]           slot_wide;
	logic [ugam_pkg::SLOT_W-1:0]         slot;
	logic                                mapped;
	logic [ugam_pkg::CFG_W-1:0]          cols_eff;
	logic [ugam_pkg::CFG_W-1:0]          rows_eff;
	logic                                hit;
	logic                                div_done;
	ugam_pkg::div_res_t                  div_res;

	assign cfg_ready  = 1'b1;
	assign text_stall = state_q != ST_IDLE;
	assign text_take  = text_valid && !text_stall;
	assign out_free   = !glyph_valid_q || !glyph_stall;
	assign last_res   = {1'b0, idx_q} == (nres_q - 1'b1);
	assign cur_cp     = idx_q ? cp1_q : cp0_q;

	assign cols_eff = (cols_q > ugam_pkg::ATLAS_MAX) ? ugam_pkg::ATLAS_MAX : cols_q;
	assign rows_eff = (rows_q > ugam_pkg::ATLAS_MAX) ? ugam_pkg::ATLAS_MAX : rows_q;

	// Byte decode: settle the results of this byte and the next sequence state.
	always_comb begin
		logic [ugam_pkg::LEN_W-1:0]  lb;
		logic [ugam_pkg::LEN_W-1:0]  lh;
		logic [ugam_pkg::BYTE_W-1:0] p1;
		logic [ugam_pkg::BYTE_W-1:0] p2;
		logic                        open;
		lb     = ugam_pkg::lead_len(text_byte);
		lh     = ugam_pkg::lead_len(held_q[1]);
		p1     = (hcnt_q >= 2'd2) ? held_q[1] : text_byte;
		p2     = (hcnt_q == 2'd3) ? held_q[2] : text_byte;
		open   = (need_q != '0) && (hcnt_q != '0);
		held_d = held_q;
		hcnt_d = hcnt_q;
		need_d = need_q;
		nres_d = '0;
		cpa_d  = {13'b0, text_byte};
		cpb_d  = {13'b0, text_byte};
		if (!open) begin
			hcnt_d = '0;
			need_d = '0;
			if (lb == 3'd1) begin
				nres_d = 2'd1;
			end else if (lb >= 3'd2 && !string_end) begin
				held_d[0] = text_byte;
				hcnt_d    = 2'd1;
				need_d    = lb;
			end
		end else if ({1'b0, hcnt_q} + 3'd1 == need_q) begin
			nres_d = 2'd1;
			cpa_d  = ugam_pkg::assemble(held_q[0], p1, p2, text_byte, need_q);
			hcnt_d = '0;
			need_d = '0;
		end else if (string_end) begin
			// Drop the lead and decode the tail again as fresh leads.
			hcnt_d = '0;
			need_d = '0;
			if (hcnt_q == 2'd2) begin
				if (lh == 3'd1) begin
					nres_d = 2'd1;
					cpa_d  = {13'b0, held_q[1]};
					if (lb == 3'd1)
						nres_d = 2'd2;
				end else if (lh == 3'd2) begin
					nres_d = 2'd1;
					cpa_d  = ugam_pkg::assemble(held_q[1], text_byte, text_byte,
						text_byte, 3'd2);
				end else if (lb == 3'd1) begin
					nres_d = 2'd1;
				end
			end else if (lb == 3'd1) begin
				nres_d = 2'd1;
			end
		end else begin
			held_d[(hcnt_q == 2'd3) ? 2'd2 : hcnt_q] = text_byte;
			hcnt_d = hcnt_q + 1'b1;
		end
	end

	always_comb begin
		mapped    = 1'b0;
		slot_wide = '0;
		if (cur_cp inside {[ugam_pkg::CP_ASCII_LO:ugam_pkg::CP_ASCII_HI]}) begin
			mapped    = 1'b1;
			slot_wide = cur_cp - ugam_pkg::CP_ASCII_LO;
		end else if (cur_cp inside {[ugam_pkg::CP_HANGUL_LO:ugam_pkg::CP_HANGUL_HI]}) begin
			mapped    = 1'b1;
			slot_wide = cur_cp - ugam_pkg::CP_HANGUL_LO + ugam_pkg::SLOT_HANGUL_BASE;
		end
	end

	assign slot = slot_wide[ugam_pkg::SLOT_W-1:0];
	assign hit  = mapped && (cols_eff != '0)
		&& (div_res.quot < {{(ugam_pkg::SLOT_W - ugam_pkg::CFG_W){1'b0}}, rows_eff});

	ugam_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (slot),
		.divisor  (cols_eff),
		.done     (div_done),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ugam_pkg::CFG_RESET;
			rows_q <= ugam_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ugam_pkg::REG_COLS: cols_q <= cfg_data;
				ugam_pkg::REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			held_q[0]     <= '0;
			held_q[1]     <= '0;
			held_q[2]     <= '0;
			hcnt_q        <= '0;
			need_q        <= '0;
			ord_q         <= '0;
			nres_q        <= '0;
			idx_q         <= 1'b0;
			end_q         <= 1'b0;
			start_q       <= 1'b0;
			glyph_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (glyph_valid_q && !glyph_stall)
				glyph_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (text_take) begin
						held_q <= held_d;
						hcnt_q <= hcnt_d;
						need_q <= need_d;
						nres_q <= nres_d;
						idx_q  <= 1'b0;
						end_q  <= string_end;
						if (nres_d != '0) begin
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end else if (string_end) begin
							ord_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						glyph_valid_q <= 1'b1;
						if (ord_q < ugam_pkg::ORDINAL_CAP)
							ord_q <= ord_q + 1'b1;
						if (last_res) begin
							// Ordinals restart after the final byte of a string.
							if (end_q)
								ord_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= 1'b1;
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && text_take) begin
			cp0_q <= cpa_d;
			cp1_q <= cpb_d;
		end
		if (state_q == ST_EMIT && out_free) begin
			code_point_q    <= cur_cp;
			found_q         <= hit;
			cell_column_q   <= hit ? div_res.rem[ugam_pkg::COL_W-1:0] : '0;
			cell_row_q      <= hit ? div_res.quot[ugam_pkg::COL_W-1:0] : '0;
			glyph_ordinal_q <= ord_q;
			run_last_q      <= last_res;
		end
	end

	assign glyph_valid   = glyph_valid_q;
	assign code_point    = code_point_q;
	assign found         = found_q;
	assign cell_column   = cell_column_q;
	assign cell_row      = cell_row_q;
	assign glyph_ordinal = glyph_ordinal_q;
	assign run_last      = run_last_q;

	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		text_take |-> state_q == ST_IDLE)
		else $error("text transaction taken while busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> nres_q != '0)
		else $error("sequencer busy with no pending glyph");

	a_miss_zero_cell: assert property (@(posedge clk) disable iff (!arst_n)
		glyph_valid_q && !found_q |-> cell_column_q == '0 && cell_row_q == '0)
		else $error("glyph not found but cell is nonzero");

	a_launch_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> state_q == ST_DIV)
		else $error("divider launched outside the divide state");

endmodule

[sim/tb_utf8_glyph_atlas_mapper_unit.sv]
// Self-checking testbench for the UTF-8 glyph atlas mapper with its own decoder predictor.
`timescale 1ns / 1ps

module tb_utf8_glyph_atlas_mapper_unit;

	localparam int CP_W  = ugam_pkg::CP_W;
	localparam int COL_W = ugam_pkg::COL_W;
	localparam int ORD_W = ugam_pkg::ORD_W;
	localparam int CFG_W = ugam_pkg::CFG_W;
	localparam int ORD_CAP = ugam_pkg::ORD_CAP_INT;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [7:0] val;
		logic       fin;
	} text_item_t;

	typedef struct {
		logic [CP_W-1:0]  cp;
		logic             hit;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row;
		logic [ORD_W-1:0] ord;
		logic             last;
	} glyph_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = ugam_pkg::REG_COLS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic text_valid = 1'b0;
	logic text_stall;
	logic [7:0] text_byte = '0;
	logic string_end = 1'b0;
	logic glyph_valid;
	logic glyph_stall = 1'b0;
	logic [CP_W-1:0] code_point;
	logic found;
	logic [COL_W-1:0] cell_column;
	logic [COL_W-1:0] cell_row;
	logic [ORD_W-1:0] glyph_ordinal;
	logic run_last;

	utf8_glyph_atlas_mapper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.string_end(string_end),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.code_point(code_point),
		.found(found),
		.cell_column(cell_column),
		.cell_row(cell_row),
		.glyph_ordinal(glyph_ordinal),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	// Decoder state as the predictor sees it.
	logic [CFG_W-1:0] atlas_cols_q = ugam_pkg::CFG_RESET;
	logic [CFG_W-1:0] atlas_rows_q = ugam_pkg::CFG_RESET;
	logic [2:0][7:0] held_q = '0;
	int held_cnt = 0;
	int need_len = 0;
	int ordinal = 0;

	text_item_t text_pending[$];
	glyph_t glyph_expect[$];
	glyph_t byte_glyphs[$];
	logic [7:0] str_buf[$];

	int errors = 0;
	int items_sent = 0;
	int unsigned send_gap_max = 4;
	int unsigned sink_stall_max = 4;
	int unsigned hold_requests = 0;

	function automatic int seq_len(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] join_seq(input logic [3:0][7:0] p, input int len);
		case (len)
			1:       return CP_W'(p[0]);
			2:       return CP_W'({p[0][4:0], p[1][5:0]});
			3:       return CP_W'({p[0][3:0], p[1][5:0], p[2][5:0]});
			default: return {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
		endcase
	endfunction

	// Look up one code point in the atlas and advance the ordinal.
	function automatic void add_glyph(input logic [CP_W-1:0] cp);
		int unsigned cols;
		int unsigned rows;
		int unsigned slot;
		int unsigned q;
		bit mapped;
		glyph_t g;
		if (byte_glyphs.size() >= 2)
			return;
		cols = (atlas_cols_q > 1024) ? 1024 : atlas_cols_q;
		rows = (atlas_rows_q > 1024) ? 1024 : atlas_rows_q;
		mapped = 1'b1;
		slot = 0;
		if (cp >= 32 && cp <= 126)
			slot = cp - 32;
		else if (cp >= 'hAC00 && cp <= 'hD7A3)
			slot = cp - 'hAC00 + 95;
		else
			mapped = 1'b0;
		g.cp = cp;
		g.hit = 1'b0;
		g.col = '0;
		g.row = '0;
		g.ord = ORD_W'(ordinal);
		g.last = 1'b0;
		if (mapped && cols != 0) begin
			q = slot / cols;
			if (q < rows) begin
				g.hit = 1'b1;
				g.col = COL_W'(slot % cols);
				g.row = COL_W'(q);
			end
		end
		byte_glyphs.push_back(g);
		if (ordinal < ORD_CAP)
			ordinal++;
	endfunction

	// Decode a closed run of bytes; a lead without enough bytes behind it is skipped.
	function automatic void decode_tail(input logic [3:0][7:0] p, input int n);
		int i;
		int l;
		logic [3:0][7:0] w;
		i = 0;
		while (i < n) begin
			l = seq_len(p[i]);
			if (l != 0 && i + l <= n) begin
				w = p >> (8 * i);
				add_glyph(join_seq(w, l));
				i += l;
			end else begin
				i++;
			end
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] t;
		int n;
		int i;
		glyph_t g;
		t = '0;
		byte_glyphs.delete();
		if (need_len == 0 || held_cnt == 0) begin
			n = seq_len(b);
			need_len = 0;
			held_cnt = 0;
			if (n == 1) begin
				add_glyph(CP_W'(b));
			end else if (n >= 2 && !fin) begin
				held_q[0] = b;
				held_cnt = 1;
				need_len = n;
			end
		end else if (held_cnt + 1 == need_len) begin
			for (i = 0; i < held_cnt; i++)
				t[i] = held_q[i];
			t[held_cnt] = b;
			decode_tail(t, held_cnt + 1);
			held_cnt = 0;
			need_len = 0;
		end else if (fin) begin
			// drop the lead and decode what follows it as fresh leads
			for (i = 1; i < held_cnt; i++)
				t[i-1] = held_q[i];
			t[held_cnt-1] = b;
			n = held_cnt;
			held_cnt = 0;
			need_len = 0;
			decode_tail(t, n);
		end else begin
			held_q[held_cnt] = b;
			held_cnt++;
		end
		if (fin)
			ordinal = 0;
		foreach (byte_glyphs[k]) begin
			g = byte_glyphs[k];
			g.last = (k == byte_glyphs.size() - 1);
			glyph_expect.push_back(g);
		end
	endfunction

	// Driver: present queued bytes, hold a stalled transaction, idle at random.
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		text_item_t it;
		if (!arst_n) begin
			text_valid <= 1'b0;
			send_gap <= 0;
		end else if (!(text_valid && text_stall)) begin
			if (text_valid)
				decode_byte(text_byte, string_end);
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				text_valid <= 1'b0;
			end else if (text_pending.size() != 0) begin
				it = text_pending.pop_front();
				text_byte <= it.val;
				string_end <= it.fin;
				text_valid <= 1'b1;
				send_gap <= $urandom_range(send_gap_max, 0);
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each glyph transaction and stall at random.
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned holds_served = 0;
	always @(posedge clk or negedge arst_n) begin
		glyph_t g;
		int unsigned nxt;
		if (!arst_n) begin
			glyph_stall <= 1'b0;
		end else begin
			nxt = (stall_left != 0) ? stall_left - 1 : 0;
			if (glyph_valid && !glyph_stall) begin
				nxt = $urandom_range(sink_stall_max, 0);
				if (glyph_expect.size() == 0) begin
					$error("glyph with nothing expected: code_point %0h", code_point);
					errors++;
				end else begin
					g = glyph_expect.pop_front();
					if (code_point !== g.cp) begin
						$error("code_point expected %0h actual %0h", g.cp, code_point);
						errors++;
					end
					if (found !== g.hit) begin
						$error("found expected %0d actual %0d", g.hit, found);
						errors++;
					end
					if (cell_column !== g.col) begin
						$error("cell_column expected %0d actual %0d", g.col, cell_column);
						errors++;
					end
					if (cell_row !== g.row) begin
						$error("cell_row expected %0d actual %0d", g.row, cell_row);
						errors++;
					end
					if (glyph_ordinal !== g.ord) begin
						$error("glyph_ordinal expected %0d actual %0d", g.ord, glyph_ordinal);
						errors++;
					end
					if (run_last !== g.last) begin
						$error("run_last expected %0d actual %0d", g.last, run_last);
						errors++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			stall_left = nxt;
			glyph_stall <= (nxt != 0) || (hold_left != 0);
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((text_valid && !text_stall) || (glyph_valid && !glyph_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("utf8_glyph_atlas_mapper_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void put_byte(input logic [7:0] v, input logic fin);
		text_item_t it;
		it.val = v;
		it.fin = fin;
		text_pending.push_back(it);
		items_sent++;
	endfunction

	function automatic void flush_string();
		foreach (str_buf[k])
			put_byte(str_buf[k], k == str_buf.size() - 1);
		str_buf.delete();
	endfunction

	function automatic void add_cp(input int unsigned cp);
		logic [20:0] c;
		c = 21'(cp);
		if (cp < 'h80) begin
			str_buf.push_back(c[7:0]);
		end else if (cp < 'h800) begin
			str_buf.push_back({3'b110, c[10:6]});
			str_buf.push_back({2'b10, c[5:0]});
		end else if (cp < 'h10000) begin
			str_buf.push_back({4'b1110, c[15:12]});
			str_buf.push_back({2'b10, c[11:6]});
			str_buf.push_back({2'b10, c[5:0]});
		end else begin
			str_buf.push_back({5'b11110, c[20:18]});
			str_buf.push_back({2'b10, c[17:12]});
			str_buf.push_back({2'b10, c[11:6]});
			str_buf.push_back({2'b10, c[5:0]});
		end
	endfunction

	function automatic logic [7:0] rand_lead(input int l);
		logic [7:0] r;
		r = 8'($urandom);
		case (l)
			2:       return {3'b110, r[4:0]};
			3:       return {4'b1110, r[3:0]};
			default: return {5'b11110, r[2:0]};
		endcase
	endfunction

	// One mostly well-formed string with random content.
	function automatic void gen_text_string();
		int nch;
		int pick;
		int l;
		int t;
		nch = $urandom_range(10, 1);
		for (int k = 0; k < nch; k++) begin
			pick = $urandom_range(99, 0);
			if (pick < 40)
				add_cp($urandom_range(126, 32));
			else if (pick < 55)
				add_cp('hAC00 + $urandom_range(300, 0));
			else if (pick < 65)
				add_cp($urandom_range('hD7A3, 'hAC00));
			else if (pick < 70)
				add_cp((pick & 1) ? 127 : $urandom_range(31, 0));
			else if (pick < 77)
				add_cp($urandom_range('h7FF, 'h80));
			else if (pick < 83)
				add_cp($urandom_range('hFFFF, 'h800));
			else if (pick < 88)
				add_cp($urandom_range('h1FFFFF, 'h10000));
			else if (pick < 93)
				str_buf.push_back((pick & 1) ? 8'($urandom_range('hBF, 'h80)) :
					8'($urandom_range('hFF, 'hF8)));
			else begin
				// lead followed by arbitrary, unchecked continuation bytes
				l = $urandom_range(4, 2);
				str_buf.push_back(rand_lead(l));
				repeat (l - 1) str_buf.push_back(8'($urandom));
			end
		end
		if ($urandom_range(3, 0) == 0) begin
			// cut the string off inside a sequence
			l = $urandom_range(4, 2);
			str_buf.push_back(rand_lead(l));
			t = $urandom_range(l - 2, 0);
			repeat (t) str_buf.push_back($urandom_range(1, 0) ?
				8'($urandom_range(126, 32)) : 8'($urandom));
		end
		flush_string();
	endfunction

	function automatic void gen_noise();
		repeat ($urandom_range(6, 1))
			put_byte(8'($urandom), $urandom_range(3, 0) == 0);
	endfunction

	function automatic void gen_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(9, 0) == 0)
				gen_noise();
			else
				gen_text_string();
		end
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		while (text_pending.size() != 0 || text_valid || glyph_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == ugam_pkg::REG_COLS)
			atlas_cols_q = v;
		else
			atlas_rows_q = v;
	endtask

	// Drain, let a byte with no glyph finish, then reprogram the atlas and set the send gap and sink stall limits.
	task automatic set_atlas(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
			input int unsigned gap_max, input int unsigned stall_max);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(ugam_pkg::REG_COLS, cols);
		write_reg(ugam_pkg::REG_ROWS, rows);
		@(negedge clk);
		send_gap_max = gap_max;
		sink_stall_max = stall_max;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_byte(8'd32, 1'b0);
		put_byte(8'd126, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hC3, 1'b0);
		put_byte(8'hA9, 1'b0);
		// first and last Hangul syllables
		put_byte(8'hEA, 1'b0);
		put_byte(8'hB0, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'hED, 1'b0);
		put_byte(8'h9E, 1'b0);
		put_byte(8'hA3, 1'b0);
		// largest four-byte code point
		put_byte(8'hF7, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b0);
		// stray bytes
		put_byte(8'h80, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h41, 1'b1);
		// multi-byte lead on the final byte
		put_byte(8'hC3, 1'b1);
		// string ends inside a sequence: two glyphs from the tail
		put_byte(8'hF0, 1'b0);
		put_byte(8'h41, 1'b0);
		put_byte(8'h42, 1'b1);
		// tail that holds a complete two-byte sequence
		put_byte(8'hF0, 1'b0);
		put_byte(8'hC3, 1'b0);
		put_byte(8'hA9, 1'b1);
		gen_random(200);

		set_atlas(11'd1, 11'd2047, 0, 4);
		gen_random(200);

		set_atlas(11'd2047, 11'd1, 4, 0);
		gen_random(200);

		// long receiver hold-off while the sender keeps offering
		set_atlas(11'd0, 11'd16, 0, 4);
		hold_requests++;
		gen_random(180);

		set_atlas(11'd16, 11'd0, 4, 4);
		gen_random(180);

		// one long string, no idling on either side
		set_atlas(11'd1024, 11'd1024, 0, 0);
		repeat (300) put_byte(8'($urandom_range(126, 32)), 1'b0);
		put_byte(8'h7E, 1'b1);
		put_byte(8'h20, 1'b0);
		put_byte(8'h21, 1'b1);
		wait_idle();
		send_gap_max = 4;
		sink_stall_max = 4;
		gen_random(150);

		set_atlas(11'd1, 11'd1, 4, 4);
		gen_random(150);

		set_atlas(CFG_W'($urandom_range(40, 1)), CFG_W'($urandom_range(300, 1)), 4, 4);
		gen_random(180);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("utf8_glyph_atlas_mapper_unit verification clean");
		else
			$display("utf8_glyph_atlas_mapper_unit verification failed");
		$finish;
	end

endmodule
